// ===== rtl/core/tmps_pkg.sv =====
// Shared types and constants for the triangle maximum path sum core.
// Used by tmps_cell, tmps_best and triangle_max_path_sum_core; no dependencies.
`default_nettype none

package tmps_pkg;

	localparam int unsigned ENTRY_W  = 16;
	localparam int unsigned SUM_W    = 22;
	localparam int unsigned ROWCNT_W = 7;

	localparam logic [ROWCNT_W-1:0] ROWCNT_RST = 7'd64;

	typedef logic signed [ENTRY_W-1:0] entry_t;
	typedef logic signed [SUM_W-1:0]   sum_t;

	localparam sum_t SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
	localparam sum_t SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};

	typedef struct packed {
		sum_t sum;
		logic last_row;
		logic last_item;
	} step_t;

endpackage

`default_nettype wire

// ===== rtl/core/tmps_cell.sv =====
// One cell of the best-sum line: holds one path sum and passes it to its lower neighbour.
// Depends on tmps_pkg.
`default_nettype none

module tmps_cell #(
	parameter int unsigned CELL_IDX = 0,
	parameter int unsigned IDX_W    = 6
) (
	input  wire logic                  clk,
	input  wire logic                  shift_en,
	input  wire logic [IDX_W-1:0]      wr_idx,
	input  wire tmps_pkg::sum_t        wr_sum,
	input  wire tmps_pkg::sum_t        upper_sum,
	output tmps_pkg::sum_t             sum_q
);

	localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

	always_ff @(posedge clk) begin
		if (shift_en) begin
			if (wr_idx == MY_IDX) begin
				sum_q <= wr_sum;
			end else begin
				sum_q <= upper_sum;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tmps_best.sv =====
// Running maximum over the last row and the output register of the result channel.
// Depends on tmps_pkg.
`default_nettype none

module tmps_best (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          step_valid,
	input  wire tmps_pkg::step_t step,
	output logic               step_ready,
	output logic               res_valid,
	input  wire logic          res_ready,
	output tmps_pkg::sum_t     res_sum
);

	tmps_pkg::sum_t best_q;
	tmps_pkg::sum_t best_nxt;
	logic           take;

	assign step_ready = !(step.last_item && res_valid && !res_ready);
	assign take       = step_valid && step_ready;
	assign best_nxt   = (step.sum > best_q) ? step.sum : best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q    <= tmps_pkg::SUM_MIN;
			res_valid <= 1'b0;
		end else begin
			if (take && step.last_row && step.last_item) begin
				res_valid <= 1'b1;
			end else if (res_ready) begin
				res_valid <= 1'b0;
			end
			if (take && step.last_row) begin
				if (step.last_item) begin
					best_q <= tmps_pkg::SUM_MIN;
				end else begin
					best_q <= best_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && step.last_row && step.last_item) begin
			res_sum <= best_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/triangle_max_path_sum_core.sv =====
// Top level of the triangle maximum path sum core.
// Depends on tmps_pkg, tmps_cell and tmps_best.
//
// Triangle entries arrive on the s_axis channel, one signed 16-bit entry per transfer,
// row by row and left to right; row r holds r entries and cfg_wr_data sets the row count.
// After the last entry of the last row, the largest top-to-bottom path sum leaves on the
// m_axis channel as one transfer, and the position counters return to the first row.
// The best sums of the previous row live in a chain of MAX_ROWS cells; each accepted entry
// shifts the chain by one place and writes its new sum at the cell given by the row
// index, so the parent above is always read from the first cell.
// One entry is taken every cycle while s_axis_tready is high. After the transfer of the
// final entry, the result passes the adder stage register, then the running maximum.
// The feedback loop is the parent select, add and line write through the first cell.
// Reset clears the counters, sets the row count to 64 and empties the result register.
// If the receiver stalls, entries keep flowing until a second result is ready; the
// s_axis channel then holds off until the waiting result has been taken.
// The user must make row count writes only while the core is idle; not enforced here.
`default_nettype none

module triangle_max_path_sum_core #(
	parameter int unsigned MAX_ROWS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [6:0]  cfg_wr_data,   // row_count
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // entry_value
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [23:0]      m_axis_tdata   // max_path_sum, then zero padding
);

	localparam int unsigned IDX_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int unsigned LW    = (IDX_W + 1 > 8) ? IDX_W + 1 : 8;

	logic [tmps_pkg::ROWCNT_W-1:0] row_count_q;
	logic [IDX_W-1:0]              row_q;
	logic [IDX_W-1:0]              col_q;
	tmps_pkg::sum_t                left_q;

	tmps_pkg::sum_t                cell_q [MAX_ROWS];

	logic                          acc;
	tmps_pkg::entry_t              entry;
	tmps_pkg::sum_t                above;
	tmps_pkg::sum_t                parent;
	logic signed [tmps_pkg::SUM_W:0] sum_wide;
	tmps_pkg::sum_t                sum;
	logic                          last_col;
	logic                          last_row;
	logic [LW-1:0]                 rows_ext;
	logic [LW-1:0]                 rows_cl;
	logic [LW-1:0]                 rows_m1;

	logic                          valid_s1;
	tmps_pkg::step_t               step_s1;
	logic                          step_ready;
	tmps_pkg::sum_t                res_sum;

	assign s_axis_tready = !valid_s1 || step_ready;
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign entry         = s_axis_tdata;
	assign above         = cell_q[0];

	always_comb begin
		rows_ext = LW'(row_count_q);
		if (rows_ext == '0) begin
			rows_cl = LW'(1);
		end else if (rows_ext > LW'(MAX_ROWS)) begin
			rows_cl = LW'(MAX_ROWS);
		end else begin
			rows_cl = rows_ext;
		end
		rows_m1  = rows_cl - LW'(1);
		last_row = LW'(row_q) >= rows_m1;
		last_col = col_q == row_q;

		if (row_q == '0) begin
			parent = '0;
		end else if (col_q == '0) begin
			parent = above;
		end else if (last_col) begin
			parent = left_q;
		end else begin
			parent = (above > left_q) ? above : left_q;
		end

		sum_wide = (tmps_pkg::SUM_W + 1)'(entry) + (tmps_pkg::SUM_W + 1)'(parent);
		if (sum_wide > (tmps_pkg::SUM_W + 1)'(tmps_pkg::SUM_MAX)) begin
			sum = tmps_pkg::SUM_MAX;
		end else if (sum_wide < (tmps_pkg::SUM_W + 1)'(tmps_pkg::SUM_MIN)) begin
			sum = tmps_pkg::SUM_MIN;
		end else begin
			sum = sum_wide[tmps_pkg::SUM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= tmps_pkg::ROWCNT_RST;
			row_q       <= '0;
			col_q       <= '0;
			left_q      <= '0;
			valid_s1    <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				row_count_q <= cfg_wr_data;
			end
			if (acc) begin
				if (last_col) begin
					col_q  <= '0;
					left_q <= '0;
					if (last_row) begin
						row_q <= '0;
					end else begin
						row_q <= row_q + IDX_W'(1);
					end
				end else begin
					col_q  <= col_q + IDX_W'(1);
					left_q <= above;
				end
				valid_s1 <= 1'b1;
			end else if (step_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			step_s1.sum       <= sum;
			step_s1.last_row  <= last_row;
			step_s1.last_item <= last_row && last_col;
		end
	end

	for (genvar i = 0; i < MAX_ROWS; i++) begin : g_cell
		tmps_pkg::sum_t upper;
		if (i == MAX_ROWS - 1) begin : g_end
			assign upper = cell_q[i];
		end else begin : g_mid
			assign upper = cell_q[i+1];
		end
		tmps_cell #(
			.CELL_IDX (i),
			.IDX_W    (IDX_W)
		) u_cell (
			.clk       (clk),
			.shift_en  (acc),
			.wr_idx    (row_q),
			.wr_sum    (sum),
			.upper_sum (upper),
			.sum_q     (cell_q[i])
		);
	end

	tmps_best u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.step_valid (valid_s1),
		.step       (step_s1),
		.step_ready (step_ready),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res_sum    (res_sum)
	);

	assign m_axis_tdata = {2'b00, res_sum};

endmodule

`default_nettype wire
